/* design/i2cms_pkg.sv */
// Shared types and constants for the I2C master byte sequencer.
package i2cms_pkg;

  // Command codes carried with each input item.
  localparam logic [2:0] CMD_NONE  = 3'd0;
  localparam logic [2:0] CMD_START = 3'd1;
  localparam logic [2:0] CMD_STOP  = 3'd2;
  localparam logic [2:0] CMD_WRITE = 3'd3;
  localparam logic [2:0] CMD_READ  = 3'd4;
  localparam logic [2:0] CMD_WACK  = 3'd5;

  // Configuration register indexes.
  localparam logic CFG_HALF_PERIOD = 1'b0;
  localparam logic CFG_ACK_TIMEOUT = 1'b1;

  // Reset values of the configuration registers.
  localparam logic [15:0] HALF_PERIOD_RST = 16'd2;
  localparam logic [7:0]  ACK_TIMEOUT_RST = 8'd250;

  // Bus sequence phases, one-hot.
  typedef enum logic [13:0] {
    PH_IDLE = 14'b00000000000001,
    PH_ST1  = 14'b00000000000010,
    PH_ST2  = 14'b00000000000100,
    PH_SP1  = 14'b00000000001000,
    PH_SP2  = 14'b00000000010000,
    PH_WA1  = 14'b00000000100000,
    PH_WA2  = 14'b00000001000000,
    PH_POLL = 14'b00000010000000,
    PH_WB_H = 14'b00000100000000,
    PH_WB_L = 14'b00001000000000,
    PH_RB_L = 14'b00010000000000,
    PH_RB_H = 14'b00100000000000,
    PH_AK_L = 14'b01000000000000,
    PH_AK_H = 14'b10000000000000
  } phase_e;

  // One input item: a tick with an optional command and the SDA sample.
  typedef struct packed {
    logic [2:0] command;
    logic [7:0] tx_byte;
    logic       send_ack;
    logic       sda_in;
  } item_t;

  // One result item: bus levels and status after the tick.
  typedef struct packed {
    logic       ack_error;
    logic [7:0] rx_byte;
    logic       done_res;
    logic       busy_res;
    logic       sda_release;
    logic       scl;
  } result_t;

endpackage

/* design/i2cms_core.sv */
// Bus sequencer state and its per-tick next-state logic.
module i2cms_core #(
  parameter int DELAY_COUNT_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                adv_i,
  input  i2cms_pkg::item_t    item_i,
  input  logic [15:0]         half_period_i,
  input  logic [7:0]          ack_timeout_i,
  output i2cms_pkg::result_t  res_o
);

  localparam int CmpW = (DELAY_COUNT_BITS > 16) ? DELAY_COUNT_BITS : 16;
  localparam logic [CmpW-1:0] DlyMax = CmpW'((65'd1 << DELAY_COUNT_BITS) - 65'd1);
  localparam logic [DELAY_COUNT_BITS-1:0] DlyOne = DELAY_COUNT_BITS'(1);

  i2cms_pkg::phase_e             phase_q, phase_d;
  logic [DELAY_COUNT_BITS-1:0]   delay_q, delay_d;
  logic [3:0]                    bit_q, bit_d;
  logic [7:0]                    shift_q, shift_d;
  logic [8:0]                    poll_q, poll_d;
  logic                          scl_q, scl_d;
  logic                          sda_q, sda_d;
  logic                          ack_q, ack_d;
  logic [7:0]                    rx_q, rx_d;
  logic                          err_q, err_d;
  logic                          done;

  logic [CmpW-1:0]               hp_ext;
  logic [DELAY_COUNT_BITS-1:0]   dly_load;
  logic [8:0]                    poll_inc;
  logic                          poll_over;

  // Step length, saturated to the counter width.
  assign hp_ext   = CmpW'(half_period_i);
  assign dly_load = (hp_ext > DlyMax) ? DELAY_COUNT_BITS'(DlyMax)
                                      : DELAY_COUNT_BITS'(hp_ext);

  // The first poll of a wait-ack counts from zero.
  assign poll_inc  = ((phase_q == i2cms_pkg::PH_POLL) ? poll_q : 9'd0) + 9'd1;
  assign poll_over = poll_inc > {1'b0, ack_timeout_i};

  // Next state for one tick.
  always_comb begin
    phase_d = phase_q;
    delay_d = delay_q;
    bit_d   = bit_q;
    shift_d = shift_q;
    poll_d  = poll_q;
    scl_d   = scl_q;
    sda_d   = sda_q;
    ack_d   = ack_q;
    rx_d    = rx_q;
    err_d   = err_q;
    done    = 1'b0;
    if (phase_q == i2cms_pkg::PH_IDLE) begin
      case (item_i.command)
        i2cms_pkg::CMD_START: begin
          phase_d = i2cms_pkg::PH_ST1; scl_d = 1'b1; sda_d = 1'b1; delay_d = dly_load;
        end
        i2cms_pkg::CMD_STOP: begin
          phase_d = i2cms_pkg::PH_SP1; scl_d = 1'b0; sda_d = 1'b0; delay_d = dly_load;
        end
        i2cms_pkg::CMD_WRITE: begin
          bit_d   = 4'd0;
          shift_d = {item_i.tx_byte[6:0], 1'b0};
          phase_d = i2cms_pkg::PH_WB_H; scl_d = 1'b1; sda_d = item_i.tx_byte[7];
          delay_d = dly_load;
        end
        i2cms_pkg::CMD_READ: begin
          ack_d   = item_i.send_ack;
          shift_d = 8'd0;
          bit_d   = 4'd0;
          phase_d = i2cms_pkg::PH_RB_L; scl_d = 1'b0; sda_d = 1'b1; delay_d = dly_load;
        end
        i2cms_pkg::CMD_WACK: begin
          phase_d = i2cms_pkg::PH_WA1; sda_d = 1'b1; delay_d = dly_load;
        end
        default: ;
      endcase
    end else if (phase_q == i2cms_pkg::PH_POLL || (phase_q == i2cms_pkg::PH_WA2 &&
                 delay_q <= DlyOne)) begin
      // Acknowledge poll: low SDA finishes, too many high polls start a stop.
      phase_d = i2cms_pkg::PH_POLL;
      if (!item_i.sda_in) begin
        scl_d   = 1'b0;
        err_d   = 1'b0;
        phase_d = i2cms_pkg::PH_IDLE;
        done    = 1'b1;
        poll_d  = (phase_q == i2cms_pkg::PH_POLL) ? poll_q : 9'd0;
      end else begin
        poll_d = poll_inc;
        if (poll_over) begin
          err_d   = 1'b1;
          phase_d = i2cms_pkg::PH_SP1; scl_d = 1'b0; sda_d = 1'b0; delay_d = dly_load;
        end
      end
    end else if (delay_q > DlyOne) begin
      delay_d = delay_q - DlyOne;
    end else begin
      case (phase_q)
        i2cms_pkg::PH_ST1: begin
          phase_d = i2cms_pkg::PH_ST2; scl_d = 1'b1; sda_d = 1'b0; delay_d = dly_load;
        end
        i2cms_pkg::PH_ST2: begin
          scl_d = 1'b0; phase_d = i2cms_pkg::PH_IDLE; done = 1'b1;
        end
        i2cms_pkg::PH_SP1: begin
          phase_d = i2cms_pkg::PH_SP2; scl_d = 1'b1; sda_d = 1'b1; delay_d = dly_load;
        end
        i2cms_pkg::PH_SP2: begin
          phase_d = i2cms_pkg::PH_IDLE; done = 1'b1;
        end
        i2cms_pkg::PH_WA1: begin
          phase_d = i2cms_pkg::PH_WA2; scl_d = 1'b1; sda_d = 1'b1; delay_d = dly_load;
        end
        i2cms_pkg::PH_WB_H: begin
          bit_d   = bit_q + 4'd1;
          phase_d = i2cms_pkg::PH_WB_L; scl_d = 1'b0; delay_d = dly_load;
        end
        i2cms_pkg::PH_WB_L: begin
          if (bit_q >= 4'd8) begin
            phase_d = i2cms_pkg::PH_IDLE; done = 1'b1;
          end else begin
            shift_d = {shift_q[6:0], 1'b0};
            phase_d = i2cms_pkg::PH_WB_H; scl_d = 1'b1; sda_d = shift_q[7];
            delay_d = dly_load;
          end
        end
        i2cms_pkg::PH_RB_L: begin
          shift_d = {shift_q[6:0], item_i.sda_in};
          bit_d   = bit_q + 4'd1;
          phase_d = i2cms_pkg::PH_RB_H; scl_d = 1'b1; sda_d = 1'b1; delay_d = dly_load;
        end
        i2cms_pkg::PH_RB_H: begin
          if (bit_q >= 4'd8) begin
            phase_d = i2cms_pkg::PH_AK_L; scl_d = 1'b0; sda_d = ~ack_q;
          end else begin
            phase_d = i2cms_pkg::PH_RB_L; scl_d = 1'b0; sda_d = 1'b1;
          end
          delay_d = dly_load;
        end
        i2cms_pkg::PH_AK_L: begin
          phase_d = i2cms_pkg::PH_AK_H; scl_d = 1'b1; delay_d = dly_load;
        end
        i2cms_pkg::PH_AK_H: begin
          scl_d = 1'b0; rx_d = shift_q; phase_d = i2cms_pkg::PH_IDLE; done = 1'b1;
        end
        default: phase_d = i2cms_pkg::PH_IDLE;
      endcase
    end
  end

  // State registers advance once per item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= i2cms_pkg::PH_IDLE;
      delay_q <= '0;
      bit_q   <= '0;
      shift_q <= '0;
      poll_q  <= '0;
      scl_q   <= 1'b1;
      sda_q   <= 1'b1;
      ack_q   <= 1'b0;
      rx_q    <= '0;
      err_q   <= 1'b0;
    end else if (adv_i) begin
      phase_q <= phase_d;
      delay_q <= delay_d;
      bit_q   <= bit_d;
      shift_q <= shift_d;
      poll_q  <= poll_d;
      scl_q   <= scl_d;
      sda_q   <= sda_d;
      ack_q   <= ack_d;
      rx_q    <= rx_d;
      err_q   <= err_d;
    end
  end

  // Result reflects the levels after this tick's update.
  always_comb begin
    res_o.scl         = scl_d;
    res_o.sda_release = sda_d;
    res_o.busy_res    = (phase_d != i2cms_pkg::PH_IDLE);
    res_o.done_res    = done;
    res_o.rx_byte     = rx_d;
    res_o.ack_error   = err_d;
  end

endmodule

/* design/i2c_master_byte_sequencer_unit.sv */
// Each accepted item is held in the input register, which feeds the sequencer
// state update and the result register; the result is registered when the item
// advances. Throughput: one item per cycle while the result side is not stalled.
// While a result waits, the input side takes at most one more item and then stalls.
// Reset (rst_ni low, asynchronous) empties both registers, idles the bus
// sequencer with SCL and SDA released and loads the configuration defaults.
module i2c_master_byte_sequencer_unit #(
  parameter int DELAY_COUNT_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write port.
  input  logic        cfg_we_i,
  input  logic        cfg_addr_i,
  input  logic [15:0] cfg_wdata_i,
  // Input stream.
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,  // tx_byte[7:0], send_ack[8], sda_in[9], zeros
  input  logic [2:0]  s_axis_tuser_i,  // command[2:0]
  // Result stream.
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // scl[0], sda_release[1], busy_res[2], done_res[3], rx_byte[11:4], ack_error[12]
  output logic [15:0] m_axis_tdata_o
);

  logic [15:0]         half_period_q;
  logic [7:0]          ack_timeout_q;
  logic                in_valid_q;
  i2cms_pkg::item_t    in_item_q;
  logic                out_valid_q;
  i2cms_pkg::result_t  out_res_q;
  i2cms_pkg::result_t  res;
  logic                adv;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_period_q <= i2cms_pkg::HALF_PERIOD_RST;
      ack_timeout_q <= i2cms_pkg::ACK_TIMEOUT_RST;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        i2cms_pkg::CFG_HALF_PERIOD: half_period_q <= cfg_wdata_i;
        i2cms_pkg::CFG_ACK_TIMEOUT: ack_timeout_q <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  // An item moves on when the result register is free or being drained.
  assign adv             = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || adv;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_item_q.command  <= s_axis_tuser_i;
      in_item_q.tx_byte  <= s_axis_tdata_i[7:0];
      in_item_q.send_ack <= s_axis_tdata_i[8];
      in_item_q.sda_in   <= s_axis_tdata_i[9];
    end
  end

  i2cms_core #(
    .DELAY_COUNT_BITS(DELAY_COUNT_BITS)
  ) u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .adv_i         (adv),
    .item_i        (in_item_q),
    .half_period_i (half_period_q),
    .ack_timeout_i (ack_timeout_q),
    .res_o         (res)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_res_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {3'b000, out_res_q};

endmodule

/* design/i2cms_checker.sv */
// Port-level checks for the I2C master byte sequencer, bound to the top level.
module i2cms_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [15:0] m_axis_tdata_o
);

  // Output register is empty once reset has been seen.
  assert property (@(posedge clk_i) !rst_ni |=> !m_axis_tvalid_o)
    else $error("result valid during reset");

  // With no result pending, the input side must be open.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("input stalled with empty result register");

  // A finishing tick never reports the bus as busy.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !(m_axis_tdata_o[3] && m_axis_tdata_o[2]))
    else $error("done and busy set together");

  // A stalled result holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=>
      (m_axis_tvalid_o && $stable(m_axis_tdata_o)))
    else $error("stalled result changed");

endmodule

bind i2c_master_byte_sequencer_unit i2cms_checker u_i2cms_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);
